// ===== design/cblq_pkg.sv =====
// shared constants, register codes and types of the cubic line blend
package cblq_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int Q_W        = 8;
	localparam int FRAC_W     = 17;
	localparam int FRAC_Q     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam int DEF_SAMPLE_FRAC_BITS = 8;
	localparam int DEF_WEIGHT_FRAC_BITS = 16;

	// the tap polynomials are evaluated at 4 * w * 2^48
	localparam int POLY_SCALE_BITS = 50;

	localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(1) << FRAC_Q;

	localparam logic [CFG_IDX_W-1:0] REG_FRAC     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HI = 2'd3;

	typedef logic [1:0] tap_t;

	localparam tap_t TAP_A = 2'd0;
	localparam tap_t TAP_B = 2'd1;
	localparam tap_t TAP_C = 2'd2;
	localparam tap_t TAP_D = 2'd3;

	typedef struct packed {
		logic signed [Q_W-1:0] zero_offset;
		logic signed [Q_W-1:0] clamp_low;
		logic signed [Q_W-1:0] clamp_high;
	} quant_cfg_t;

endpackage

// ===== design/cblq_in_if.sv =====
// input channel: four row samples and the last flag
interface cblq_in_if;
	import cblq_pkg::*;

	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] sample_a;
	logic signed [SAMPLE_W-1:0] sample_b;
	logic signed [SAMPLE_W-1:0] sample_c;
	logic signed [SAMPLE_W-1:0] sample_d;
	logic last_in;

	modport source (
		output valid, sample_a, sample_b, sample_c, sample_d, last_in,
		input  ready
	);

	modport sink (
		input  valid, sample_a, sample_b, sample_c, sample_d, last_in,
		output ready
	);

endinterface

// ===== design/cblq_out_if.sv =====
// output channel: quantized result and the last flag
interface cblq_out_if;
	import cblq_pkg::*;

	logic valid;
	logic ready;
	logic signed [Q_W-1:0] quantized;
	logic last_out;

	modport source (
		output valid, quantized, last_out,
		input  ready
	);

	modport sink (
		input  valid, quantized, last_out,
		output ready
	);

endinterface

// ===== design/cblq_wgen.sv =====
// tap weight generator: one shared polynomial pipeline, four taps in turn
module cblq_wgen #(
	parameter int WEIGHT_FRAC_BITS = cblq_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [cblq_pkg::FRAC_W-1:0] frac,
	output logic busy,
	output logic signed [WEIGHT_FRAC_BITS+3:0] weight_a,
	output logic signed [WEIGHT_FRAC_BITS+3:0] weight_b,
	output logic signed [WEIGHT_FRAC_BITS+3:0] weight_c,
	output logic signed [WEIGHT_FRAC_BITS+3:0] weight_d
);
	import cblq_pkg::*;

	localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 4;
	localparam int RSH      = POLY_SCALE_BITS - WEIGHT_FRAC_BITS;
	localparam int X_W      = FRAC_W + 1;
	localparam int X2_W     = 2 * X_W;
	localparam int X3_W     = 3 * X_W;
	localparam int VW       = X3_W + 4;

	localparam logic signed [VW-1:0] ONE_P = VW'(1) << (3 * FRAC_Q);
	localparam logic signed [VW-1:0] HALF  = VW'(1) << (RSH - 1);
	localparam logic [WEIGHT_W-1:0]  W_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

	logic busy_q;
	logic feed_on_q;
	tap_t feed_tap_q;

	logic [X_W-1:0] x_feed;
	logic far_feed;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	tap_t tap_s1, tap_s2, tap_s3, tap_s4;
	logic far_s1, far_s2;
	logic [X_W-1:0] x_s1, x_s2;
	logic [X2_W-1:0] x2_s1, x2_s2;
	logic [X3_W-1:0] x3_s2;
	logic signed [VW-1:0] cub_s3, quad_s3, v_s4;

	logic signed [VW-1:0] xe, x2e, x3e, cub, quad;
	logic [VW-1:0] rnd;
	logic signed [WEIGHT_W-1:0] w_new;
	logic signed [WEIGHT_W-1:0] weight_a_q, weight_b_q, weight_c_q, weight_d_q;

	// distance of each tap from the fraction
	always_comb begin
		case (feed_tap_q)
			TAP_A: begin
				x_feed   = {1'b0, ONE_Q16} + {1'b0, frac};
				far_feed = 1'b1;
			end
			TAP_B: begin
				x_feed   = {1'b0, frac};
				far_feed = 1'b0;
			end
			TAP_C: begin
				x_feed   = {1'b0, ONE_Q16} - {1'b0, frac};
				far_feed = 1'b0;
			end
			TAP_D: begin
				x_feed   = {ONE_Q16, 1'b0} - {1'b0, frac};
				far_feed = 1'b1;
			end
			default: begin
				x_feed   = '0;
				far_feed = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			feed_on_q  <= 1'b0;
			feed_tap_q <= TAP_A;
		end else begin
			if (start) begin
				busy_q     <= 1'b1;
				feed_on_q  <= 1'b1;
				feed_tap_q <= TAP_A;
			end else begin
				if (feed_on_q) begin
					feed_tap_q <= feed_tap_q + 2'd1;
					if (feed_tap_q == TAP_D) begin
						feed_on_q <= 1'b0;
					end
				end
				if (vld_s4 && tap_s4 == TAP_D && !feed_on_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= feed_on_q && !start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// square, then cube
	always_ff @(posedge clk) begin
		tap_s1 <= feed_tap_q;
		far_s1 <= far_feed;
		x_s1   <= x_feed;
		x2_s1  <= x_feed * x_feed;
		tap_s2 <= tap_s1;
		far_s2 <= far_s1;
		x_s2   <= x_s1;
		x2_s2  <= x2_s1;
		x3_s2  <= x2_s1 * x_s1;
	end

	// near: 5x^3 - 9x^2 + 4, far: -3x^3 + 15x^2 - 24x + 12, all scaled
	always_comb begin
		xe  = $signed({{(VW-X_W){1'b0}}, x_s2});
		x2e = $signed({{(VW-X2_W){1'b0}}, x2_s2});
		x3e = $signed({{(VW-X3_W){1'b0}}, x3_s2});
		if (far_s2) begin
			cub  = (ONE_P <<< 3) + (ONE_P <<< 2) - (x3e <<< 1) - x3e;
			quad = (x2e <<< (FRAC_Q + 4)) - (x2e <<< FRAC_Q)
				- (xe <<< (2 * FRAC_Q + 4)) - (xe <<< (2 * FRAC_Q + 3));
		end else begin
			cub  = (x3e <<< 2) + x3e + (ONE_P <<< 2);
			quad = -(x2e <<< (FRAC_Q + 3)) - (x2e <<< FRAC_Q);
		end
	end

	always_ff @(posedge clk) begin
		tap_s3  <= tap_s2;
		cub_s3  <= cub;
		quad_s3 <= quad;
		tap_s4  <= tap_s3;
		v_s4    <= cub_s3 + quad_s3;
	end

	// round half away from zero
	always_comb begin
		rnd   = v_s4 + HALF - {{(VW-1){1'b0}}, v_s4[VW-1]};
		w_new = rnd[RSH +: WEIGHT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_a_q <= '0;
			weight_b_q <= W_ONE;
			weight_c_q <= '0;
			weight_d_q <= '0;
		end else if (vld_s4) begin
			case (tap_s4)
				TAP_A: weight_a_q <= w_new;
				TAP_B: weight_b_q <= w_new;
				TAP_C: weight_c_q <= w_new;
				TAP_D: weight_d_q <= w_new;
				default: weight_a_q <= weight_a_q;
			endcase
		end
	end

	assign busy     = busy_q | start;
	assign weight_a = weight_a_q;
	assign weight_b = weight_b_q;
	assign weight_c = weight_c_q;
	assign weight_d = weight_d_q;

endmodule

// ===== design/cblq_blend.sv =====
// blend pipeline: weighted sum, rounding, zero point and clamp
module cblq_blend #(
	parameter int SAMPLE_FRAC_BITS = cblq_pkg::DEF_SAMPLE_FRAC_BITS,
	parameter int WEIGHT_FRAC_BITS = cblq_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic hold,
	input  logic signed [WEIGHT_FRAC_BITS+3:0] weight_a,
	input  logic signed [WEIGHT_FRAC_BITS+3:0] weight_b,
	input  logic signed [WEIGHT_FRAC_BITS+3:0] weight_c,
	input  logic signed [WEIGHT_FRAC_BITS+3:0] weight_d,
	input  cblq_pkg::quant_cfg_t qcfg,
	cblq_in_if.sink   din,
	cblq_out_if.source dout
);
	import cblq_pkg::*;

	localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 4;
	localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
	localparam int PAIR_W   = PROD_W + 1;
	localparam int ACC_W    = PROD_W + 2;
	localparam int RSH      = SAMPLE_FRAC_BITS + WEIGHT_FRAC_BITS;
	localparam int QR_W     = ACC_W + 1 - RSH;
	localparam int QO_W     = QR_W + 1;

	localparam logic [ACC_W:0] HALF = (ACC_W+1)'(1) << (RSH - 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic signed [SAMPLE_W-1:0] sa_s1, sb_s1, sc_s1, sd_s1;
	logic signed [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [PAIR_W-1:0] pab_s3, pcd_s3;
	logic signed [ACC_W-1:0] acc_s4;
	logic signed [QR_W-1:0] q_s5;
	logic signed [Q_W-1:0] q_s6;

	logic [ACC_W:0] rnd;
	logic signed [QO_W-1:0] q_off, lo_e, hi_e, q_clamp;

	assign rdy_s6 = !vld_s6 || dout.ready;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign din.ready = rdy_s1 && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= din.valid && !hold;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
			if (rdy_s6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	// rounding half away from zero, then zero point and clamp
	always_comb begin
		rnd     = {acc_s4[ACC_W-1], acc_s4} + HALF - {{ACC_W{1'b0}}, acc_s4[ACC_W-1]};
		q_off   = QO_W'(q_s5) + QO_W'(qcfg.zero_offset);
		lo_e    = QO_W'(qcfg.clamp_low);
		hi_e    = QO_W'(qcfg.clamp_high);
		q_clamp = q_off;
		if (q_clamp < lo_e) begin
			q_clamp = lo_e;
		end
		if (q_clamp > hi_e) begin
			q_clamp = hi_e;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sa_s1   <= din.sample_a;
			sb_s1   <= din.sample_b;
			sc_s1   <= din.sample_c;
			sd_s1   <= din.sample_d;
			last_s1 <= din.last_in;
		end
		if (rdy_s2) begin
			pa_s2   <= sa_s1 * weight_a;
			pb_s2   <= sb_s1 * weight_b;
			pc_s2   <= sc_s1 * weight_c;
			pd_s2   <= sd_s1 * weight_d;
			last_s2 <= last_s1;
		end
		if (rdy_s3) begin
			pab_s3  <= PAIR_W'(pa_s2) + PAIR_W'(pb_s2);
			pcd_s3  <= PAIR_W'(pc_s2) + PAIR_W'(pd_s2);
			last_s3 <= last_s2;
		end
		if (rdy_s4) begin
			acc_s4  <= ACC_W'(pab_s3) + ACC_W'(pcd_s3);
			last_s4 <= last_s3;
		end
		if (rdy_s5) begin
			q_s5    <= rnd[RSH +: QR_W];
			last_s5 <= last_s4;
		end
		if (rdy_s6) begin
			q_s6    <= q_clamp[Q_W-1:0];
			last_s6 <= last_s5;
		end
	end

	assign dout.valid     = vld_s6;
	assign dout.quantized = q_s6;
	assign dout.last_out  = last_s6;

endmodule

// ===== design/cubic_line_blend_quantize.sv =====
// top level: configuration registers, weight generator and blend pipeline
// an item passes the input, product, pair sum, sum, round and clamp registers in order
// throughput: one item per cycle while dout is ready and no weight update is pending
// a frac_position write holds input ready low while the shared
// polynomial pipeline forms the four tap weights one after another
// reset (asynchronous, active low) empties the pipeline and loads the weights for t = 0
module cubic_line_blend_quantize #(
	parameter int SAMPLE_FRAC_BITS = cblq_pkg::DEF_SAMPLE_FRAC_BITS,
	parameter int WEIGHT_FRAC_BITS = cblq_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [cblq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cblq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	cblq_in_if.sink    din,
	cblq_out_if.source dout
);
	import cblq_pkg::*;

	localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 4;

	logic [FRAC_W-1:0] frac_q;
	quant_cfg_t qcfg_q;
	logic wgen_start;
	logic wgen_busy;
	logic signed [WEIGHT_W-1:0] weight_a, weight_b, weight_c, weight_d;

	assign wgen_start = cfg_we && (cfg_index == REG_FRAC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q             <= '0;
			qcfg_q.zero_offset <= '0;
			qcfg_q.clamp_low   <= {1'b1, {(Q_W-1){1'b0}}};
			qcfg_q.clamp_high  <= {1'b0, {(Q_W-1){1'b1}}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAC: begin
					frac_q <= (cfg_wdata[FRAC_W-1:0] > ONE_Q16) ? ONE_Q16
						: cfg_wdata[FRAC_W-1:0];
				end
				REG_ZERO:     qcfg_q.zero_offset <= cfg_wdata[Q_W-1:0];
				REG_CLAMP_LO: qcfg_q.clamp_low   <= cfg_wdata[Q_W-1:0];
				REG_CLAMP_HI: qcfg_q.clamp_high  <= cfg_wdata[Q_W-1:0];
				default:      frac_q <= frac_q;
			endcase
		end
	end

	cblq_wgen #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_wgen (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (wgen_start),
		.frac    (frac_q),
		.busy    (wgen_busy),
		.weight_a(weight_a),
		.weight_b(weight_b),
		.weight_c(weight_c),
		.weight_d(weight_d)
	);

	cblq_blend #(
		.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS),
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.hold    (wgen_busy),
		.weight_a(weight_a),
		.weight_b(weight_b),
		.weight_c(weight_c),
		.weight_d(weight_d),
		.qcfg    (qcfg_q),
		.din     (din),
		.dout    (dout)
	);

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench of the cubic line blend: directed table, then random items against a bit-true predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cblq_pkg::*;

	localparam int SFRAC = DEF_SAMPLE_FRAC_BITS;
	localparam int WFRAC = DEF_WEIGHT_FRAC_BITS;
	localparam int WEIGHT_W = WFRAC + 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int ITEMS_PER_SETTING = 146;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_PRINTED = 30;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;

	localparam bit CHECK_MODEL = 1'b0;
	localparam bit CHECK_TABLE = 1'b1;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] a;
		logic signed [SAMPLE_W-1:0] b;
		logic signed [SAMPLE_W-1:0] c;
		logic signed [SAMPLE_W-1:0] d;
		logic last;
	} row_taps_t;

	typedef struct packed {
		logic signed [Q_W-1:0] quantized;
		logic last_out;
	} blend_result_t;

	typedef struct {
		row_kind_e kind;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] wdata;
		row_taps_t taps;
		bit from_table;
		logic signed [Q_W-1:0] quantized;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cblq_in_if din();
	cblq_out_if dout();

	cubic_line_blend_quantize i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.din(din),
		.dout(dout)
	);

	logic signed [WEIGHT_W-1:0] tap_weight [4];
	quant_cfg_t quant_cfg;
	blend_result_t expected_results[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit hold_request;
	int hold_left;
	int quiet_cycles;
	int error_count;
	int items_sent;
	int results_checked;
	int reg_writes;

	always #5 clk = ~clk;

	function automatic longint round_half_away(longint v, int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	// polynomial scaled to 4 * w * 2^48, then rounded to the weight format
	function automatic longint cubic_weight(longint x, bit far_tap);
		longint x2;
		longint x3;
		longint poly;
		x2 = x * x;
		x3 = x2 * x;
		if (far_tap) begin
			poly = -3 * x3 + 15 * x2 * 65536 - 24 * x * (longint'(1) << 32)
				+ 12 * (longint'(1) << 48);
		end else begin
			poly = 5 * x3 - 9 * x2 * 65536 + 4 * (longint'(1) << 48);
		end
		return round_half_away(poly, POLY_SCALE_BITS - WFRAC);
	endfunction

	function automatic void set_fraction(logic [FRAC_W-1:0] raw);
		longint t;
		longint one;
		one = longint'(ONE_Q16);
		t = (raw > ONE_Q16) ? one : longint'(raw);
		tap_weight[TAP_A] = WEIGHT_W'(cubic_weight(one + t, 1'b1));
		tap_weight[TAP_B] = WEIGHT_W'(cubic_weight(t, 1'b0));
		tap_weight[TAP_C] = WEIGHT_W'(cubic_weight(one - t, 1'b0));
		tap_weight[TAP_D] = WEIGHT_W'(cubic_weight(2 * one - t, 1'b1));
	endfunction

	function automatic void apply_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_FRAC: begin
				set_fraction(data[FRAC_W-1:0]);
			end
			REG_ZERO: begin
				quant_cfg.zero_offset = data[Q_W-1:0];
			end
			REG_CLAMP_LO: begin
				quant_cfg.clamp_low = data[Q_W-1:0];
			end
			REG_CLAMP_HI: begin
				quant_cfg.clamp_high = data[Q_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic blend_result_t predict_blend(row_taps_t taps);
		longint acc;
		longint q;
		longint lo;
		longint hi;
		blend_result_t res;
		acc = longint'(tap_weight[TAP_A]) * longint'($signed(taps.a))
			+ longint'(tap_weight[TAP_B]) * longint'($signed(taps.b))
			+ longint'(tap_weight[TAP_C]) * longint'($signed(taps.c))
			+ longint'(tap_weight[TAP_D]) * longint'($signed(taps.d));
		q = round_half_away(acc, SFRAC + WFRAC) + longint'($signed(quant_cfg.zero_offset));
		lo = longint'($signed(quant_cfg.clamp_low));
		hi = longint'($signed(quant_cfg.clamp_high));
		if (q < lo) q = lo;
		if (q > hi) q = hi;
		res.quantized = q[Q_W-1:0];
		res.last_out = taps.last;
		return res;
	endfunction

	function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{ROW_WRITE, index, data, '0, CHECK_MODEL, '0};
		return row;
	endfunction

	function automatic stim_row_t item_row(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
		logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] d, logic last,
		bit from_table, logic signed [Q_W-1:0] q);
		stim_row_t row;
		row = '{ROW_ITEM, REG_FRAC, '0, '{a, b, c, d, last}, from_table, q};
		return row;
	endfunction

	// mostly narrow samples so that the result is not pinned at a rail
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		logic signed [SAMPLE_W-1:0] s;
		int w;
		w = $urandom_range(1, SAMPLE_W);
		s = SAMPLE_W'($urandom);
		case ($urandom_range(0, 15))
			0: s = S_MAX;
			1: s = S_MIN;
			default: begin
				s = s <<< (SAMPLE_W - w);
				s = s >>> (SAMPLE_W - w);
			end
		endcase
		return s;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [Q_W-1:0] v);
		logic [CFG_DATA_W-Q_W-1:0] junk;
		junk = (CFG_DATA_W-Q_W)'($urandom);
		return {junk, v};
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("%0t: result %0d: %s is %0d, expected %0d", $realtime, results_checked, what,
				got, want);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		apply_write(index, data);
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_taps(row_taps_t taps, bit from_table, logic signed [Q_W-1:0] table_q);
		blend_result_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid <= 1'b1;
		din.sample_a <= taps.a;
		din.sample_b <= taps.b;
		din.sample_c <= taps.c;
		din.sample_d <= taps.d;
		din.last_in <= taps.last;
		do @(posedge clk); while (!din.ready);
		if (from_table) begin
			res.quantized = table_q;
			res.last_out = taps.last;
		end else begin
			res = predict_blend(taps);
		end
		expected_results.push_back(res);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		din.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic random_settings();
		logic [CFG_DATA_W-1:0] frac;
		logic signed [Q_W-1:0] lo;
		logic signed [Q_W-1:0] hi;
		drain();
		case ($urandom_range(0, 4))
			0: frac = '0;
			1: frac = ONE_Q16;
			2: frac = '1;
			3: frac = CFG_DATA_W'($urandom_range(0, 65536));
			default: frac = CFG_DATA_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: begin
				lo = Q_W'($urandom);
				hi = Q_W'($urandom);
			end
			1: begin
				lo = -8'sd128;
				hi = 8'sd127;
			end
			default: begin
				lo = Q_W'($urandom_range(0, 128) - 128);
				hi = Q_W'($urandom_range(0, 127));
			end
		endcase
		write_reg(REG_FRAC, frac);
		write_reg(REG_ZERO, with_junk(Q_W'($urandom)));
		write_reg(REG_CLAMP_LO, with_junk(lo));
		write_reg(REG_CLAMP_HI, with_junk(hi));
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		blend_result_t want;
		if (arst_n) begin
			if ((din.valid && din.ready) || (dout.valid && dout.ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (dout.valid && dout.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, quantized", longint'(dout.quantized), 0);
				end else begin
					want = expected_results.pop_front();
					if (dout.quantized !== want.quantized)
						report_mismatch("quantized", longint'(dout.quantized),
							longint'(want.quantized));
					if (dout.last_out !== want.last_out)
						report_mismatch("last_out", longint'(dout.last_out),
							longint'(want.last_out));
				end
				results_checked++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding", $realtime,
					WATCHDOG_LIMIT, expected_results.size());
				$display("FAIL cubic_line_blend_quantize");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t directed_rows[$];
		row_taps_t taps;
		int directed_items;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAC;
		cfg_wdata = '0;
		din.valid = 1'b0;
		din.sample_a = '0;
		din.sample_b = '0;
		din.sample_c = '0;
		din.sample_d = '0;
		din.last_in = 1'b0;
		dout.ready = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		error_count = 0;
		items_sent = 0;
		results_checked = 0;
		reg_writes = 0;
		send_idle_pct = 29;
		recv_idle_pct = 62;

		quant_cfg.zero_offset = 8'sd0;
		quant_cfg.clamp_low = -8'sd128;
		quant_cfg.clamp_high = 8'sd127;
		set_fraction('0);

		directed_rows = '{
			// after reset only the centre tap counts
			item_row(0, 0, 0, 0, 0, CHECK_TABLE, 0),
			item_row(0, 128, 0, 0, 0, CHECK_TABLE, 1),
			item_row(0, -128, 0, 0, 0, CHECK_TABLE, -1),
			item_row(0, 127, 0, 0, 1, CHECK_TABLE, 0),
			item_row(0, -129, 0, 0, 0, CHECK_TABLE, -1),
			item_row(S_MIN, S_MAX, S_MIN, S_MIN, 1, CHECK_TABLE, 127),
			item_row(S_MAX, S_MIN, S_MAX, S_MAX, 0, CHECK_TABLE, -128),
			// fraction above one saturates, leaving only tap c
			write_row(REG_FRAC, 17'h1FFFF),
			item_row(S_MAX, S_MIN, 384, S_MIN, 0, CHECK_TABLE, 2),
			item_row(0, 0, -384, 0, 1, CHECK_TABLE, -2),
			// upper bits of an 8-bit register are dropped
			write_row(REG_ZERO, 17'h1FF85),
			item_row(0, 0, 0, 0, 0, CHECK_TABLE, -123),
			item_row(0, 0, S_MIN, 0, 0, CHECK_TABLE, -128),
			item_row(0, 0, S_MAX, 0, 0, CHECK_TABLE, 127),
			// inverted bounds: clamp_high wins
			write_row(REG_CLAMP_LO, 17'h0000A),
			write_row(REG_CLAMP_HI, 17'h1E0F6),
			item_row(0, 0, S_MAX, 0, 0, CHECK_TABLE, -10),
			item_row(0, 0, S_MIN, 0, 1, CHECK_TABLE, -10),
			write_row(REG_ZERO, 17'h00000),
			write_row(REG_CLAMP_LO, 17'h00080),
			write_row(REG_CLAMP_HI, 17'h0007F),
			write_row(REG_FRAC, 17'd32768),
			item_row(S_MAX, S_MAX, S_MAX, S_MAX, 0, CHECK_MODEL, 0),
			item_row(S_MIN, S_MIN, S_MIN, S_MIN, 1, CHECK_MODEL, 0),
			item_row(S_MAX, S_MIN, S_MIN, S_MAX, 0, CHECK_MODEL, 0),
			item_row(-1000, 2000, -3000, 4000, 0, CHECK_MODEL, 0),
			write_row(REG_FRAC, 17'd1),
			item_row(S_MIN, S_MAX, S_MIN, S_MAX, 0, CHECK_MODEL, 0),
			item_row(5000, -5000, 7000, -7000, 1, CHECK_MODEL, 0),
			write_row(REG_FRAC, 17'd65535),
			item_row(S_MAX, S_MIN, S_MAX, S_MIN, 0, CHECK_MODEL, 0),
			item_row(-20000, 30000, 12345, -6789, 1, CHECK_MODEL, 0)
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain();
				write_reg(directed_rows[i].index, directed_rows[i].wdata);
			end else begin
				send_taps(directed_rows[i].taps, directed_rows[i].from_table,
					directed_rows[i].quantized);
			end
		end
		directed_items = items_sent;

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 62 : 0;
			recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 29 : 0;
			for (int setting = 0; setting < 4; setting++) begin
				random_settings();
				for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
					// receiver backs up the pipeline, later the sender waits for it to empty
					if (phase == 2 && setting == 0 && n == 20) hold_request = 1'b1;
					if (phase == 2 && setting == 0 && n == 100) drain();
					taps.a = rand_sample();
					taps.b = rand_sample();
					taps.c = rand_sample();
					taps.d = rand_sample();
					taps.last = ($urandom_range(0, 7) == 0);
					send_taps(taps, CHECK_MODEL, '0);
				end
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items (%0d from the directed table) across %0d register writes",
			items_sent, directed_items, reg_writes);
		$display("checked %0d results under three idling patterns, %0d mismatches",
			results_checked, error_count);
		if (error_count == 0) begin
			$display("PASS cubic_line_blend_quantize");
		end else begin
			$display("FAIL cubic_line_blend_quantize");
		end
		$finish;
	end

endmodule
